@@ rtl/tlpw_pkg.sv @@
// ---------------------------------------------------------------------------
// tlpw_pkg: shared types and constants of the two-level page walker
// Payload structs, status codes, the controller state type and the
// command and status structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
package tlpw_pkg;

   localparam int PAGE_BYTES   = 32;
   localparam int NUM_FRAMES   = 128;
   localparam int MEM_DEPTH    = PAGE_BYTES * NUM_FRAMES;
   localparam int ADDR_W       = $clog2(MEM_DEPTH);
   localparam int OFFSET_W     = $clog2(PAGE_BYTES);
   localparam int FRAME_W      = $clog2(NUM_FRAMES);
   localparam int INDEX_W      = 5;
   localparam int VA_W         = 15;
   localparam int BYTE_W       = 8;
   localparam int DIR_IDX_LSB  = 2 * INDEX_W;
   localparam int TBL_IDX_LSB  = INDEX_W;
   localparam int ENTRY_VALID  = 7;

   localparam logic [ADDR_W-1:0] DIR_BASE_RESET = 12'h220;

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_DIR_FAULT   = 2'd1,
      STATUS_TABLE_FAULT = 2'd2,
      STATUS_WRITE_DONE  = 2'd3
   } status_type;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] write_addr;
      logic [BYTE_W-1:0] write_data;
      logic [VA_W-1:0]   virt_addr;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] dir_index;
      logic               dir_valid;
      logic [FRAME_W-1:0] dir_frame;
      logic [INDEX_W-1:0] table_index;
      logic               table_valid;
      logic [FRAME_W-1:0] table_frame;
      logic [ADDR_W-1:0]  phys_addr;
      logic [BYTE_W-1:0]  read_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIR_CHECK,
      ST_TABLE_CHECK,
      ST_DATA
   } state_type;

   typedef enum logic [1:0] {
      ADDR_WRITE,
      ADDR_DIR,
      ADDR_TABLE,
      ADDR_DATA
   } addr_sel_type;

   typedef struct packed {
      logic         mem_en;
      logic         mem_we;
      addr_sel_type addr_sel;
      logic         req_load;
      logic         dir_load;
      logic         tbl_load;
      logic         rsp_load;
      status_type   rsp_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic entry_valid;
   } dp_stat_type;

endpackage

@@ rtl/tlpw_ctrl.sv @@
// ---------------------------------------------------------------------------
// tlpw_ctrl: walk sequencer
// Steps through the directory, table and data reads and tells the datapath
// which address to drive and when to load the result.
// ---------------------------------------------------------------------------
module tlpw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_cmd,
   input  tlpw_pkg::dp_stat_type stat,
   output tlpw_pkg::ctl_cmd_type ctl,
   output logic                  busy
);

   tlpw_pkg::state_type state_ff;
   tlpw_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlpw_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlpw_pkg::ST_IDLE: begin
            if (start && req_cmd == tlpw_pkg::CMD_TRANSLATE) begin
               state_in = tlpw_pkg::ST_DIR_CHECK;
            end
         end
         tlpw_pkg::ST_DIR_CHECK: begin
            state_in = stat.entry_valid ? tlpw_pkg::ST_TABLE_CHECK : tlpw_pkg::ST_IDLE;
         end
         tlpw_pkg::ST_TABLE_CHECK: begin
            state_in = stat.entry_valid ? tlpw_pkg::ST_DATA : tlpw_pkg::ST_IDLE;
         end
         tlpw_pkg::ST_DATA: begin
            state_in = tlpw_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlpw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl            = '0;
      ctl.addr_sel   = tlpw_pkg::ADDR_DIR;
      ctl.rsp_status = tlpw_pkg::STATUS_OK;
      busy           = 1'b1;
      unique case (state_ff)
         tlpw_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.mem_en = 1'b1;
               if (req_cmd == tlpw_pkg::CMD_WRITE) begin
                  ctl.mem_we     = 1'b1;
                  ctl.addr_sel   = tlpw_pkg::ADDR_WRITE;
                  ctl.rsp_load   = 1'b1;
                  ctl.rsp_status = tlpw_pkg::STATUS_WRITE_DONE;
               end else begin
                  ctl.addr_sel = tlpw_pkg::ADDR_DIR;
                  ctl.req_load = 1'b1;
               end
            end
         end
         tlpw_pkg::ST_DIR_CHECK: begin
            if (stat.entry_valid) begin
               ctl.mem_en   = 1'b1;
               ctl.addr_sel = tlpw_pkg::ADDR_TABLE;
               ctl.dir_load = 1'b1;
            end else begin
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = tlpw_pkg::STATUS_DIR_FAULT;
            end
         end
         tlpw_pkg::ST_TABLE_CHECK: begin
            if (stat.entry_valid) begin
               ctl.mem_en   = 1'b1;
               ctl.addr_sel = tlpw_pkg::ADDR_DATA;
               ctl.tbl_load = 1'b1;
            end else begin
               ctl.rsp_load   = 1'b1;
               ctl.rsp_status = tlpw_pkg::STATUS_TABLE_FAULT;
            end
         end
         tlpw_pkg::ST_DATA: begin
            ctl.rsp_load   = 1'b1;
            ctl.rsp_status = tlpw_pkg::STATUS_OK;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/tlpw_dpath.sv @@
// ---------------------------------------------------------------------------
// tlpw_dpath: walker datapath
// Holds the physical memory, the directory base register, the captured
// request and entries, and the registered response.
// ---------------------------------------------------------------------------
module tlpw_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  tlpw_pkg::req_type                req_data,
   input  logic                             csr_we,
   input  logic [tlpw_pkg::ADDR_W-1:0]      csr_data,
   input  tlpw_pkg::ctl_cmd_type            ctl,
   output tlpw_pkg::dp_stat_type            stat,
   output logic                             rsp_strobe,
   output tlpw_pkg::rsp_type                rsp_data
);

   logic [tlpw_pkg::BYTE_W-1:0] mem [tlpw_pkg::MEM_DEPTH];

   logic [tlpw_pkg::ADDR_W-1:0] dir_base_ff;
   logic [tlpw_pkg::VA_W-1:0]   va_ff;
   logic [tlpw_pkg::BYTE_W-1:0] dir_entry_ff;
   logic [tlpw_pkg::BYTE_W-1:0] tbl_entry_ff;
   logic [tlpw_pkg::BYTE_W-1:0] rdata_ff;
   logic                        rsp_strobe_ff;
   tlpw_pkg::rsp_type           rsp_ff;
   tlpw_pkg::rsp_type           rsp_in;
   logic [tlpw_pkg::ADDR_W-1:0] mem_addr;
   logic [tlpw_pkg::INDEX_W-1:0] req_di;

   assign req_di = req_data.virt_addr[tlpw_pkg::DIR_IDX_LSB +: tlpw_pkg::INDEX_W];

   // Memory address for the current step of the walk.
   always_comb begin
      case (ctl.addr_sel)
         tlpw_pkg::ADDR_WRITE: mem_addr = req_data.write_addr;
         tlpw_pkg::ADDR_DIR:   mem_addr = dir_base_ff +
                                          {{(tlpw_pkg::ADDR_W-tlpw_pkg::INDEX_W){1'b0}}, req_di};
         tlpw_pkg::ADDR_TABLE: mem_addr = {rdata_ff[tlpw_pkg::FRAME_W-1:0],
                                  va_ff[tlpw_pkg::TBL_IDX_LSB +: tlpw_pkg::INDEX_W]};
         tlpw_pkg::ADDR_DATA:  mem_addr = {rdata_ff[tlpw_pkg::FRAME_W-1:0],
                                  va_ff[tlpw_pkg::OFFSET_W-1:0]};
         default:              mem_addr = req_data.write_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.mem_en) begin
         if (ctl.mem_we) begin
            mem[mem_addr] <= req_data.write_data;
         end else begin
            rdata_ff <= mem[mem_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_base_ff   <= tlpw_pkg::DIR_BASE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            dir_base_ff <= csr_data;
         end
         rsp_strobe_ff <= ctl.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.req_load) begin
         va_ff <= req_data.virt_addr;
      end
      if (ctl.dir_load) begin
         dir_entry_ff <= rdata_ff;
      end
      if (ctl.tbl_load) begin
         tbl_entry_ff <= rdata_ff;
      end
      if (ctl.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // The entry just read sits in rdata_ff; earlier entries were captured.
   always_comb begin
      rsp_in        = '0;
      rsp_in.status = ctl.rsp_status;
      case (ctl.rsp_status)
         tlpw_pkg::STATUS_DIR_FAULT: begin
            rsp_in.dir_index   = va_ff[tlpw_pkg::DIR_IDX_LSB +: tlpw_pkg::INDEX_W];
            rsp_in.dir_valid   = rdata_ff[tlpw_pkg::ENTRY_VALID];
            rsp_in.dir_frame   = rdata_ff[tlpw_pkg::FRAME_W-1:0];
            rsp_in.table_index = va_ff[tlpw_pkg::TBL_IDX_LSB +: tlpw_pkg::INDEX_W];
         end
         tlpw_pkg::STATUS_TABLE_FAULT: begin
            rsp_in.dir_index   = va_ff[tlpw_pkg::DIR_IDX_LSB +: tlpw_pkg::INDEX_W];
            rsp_in.dir_valid   = dir_entry_ff[tlpw_pkg::ENTRY_VALID];
            rsp_in.dir_frame   = dir_entry_ff[tlpw_pkg::FRAME_W-1:0];
            rsp_in.table_index = va_ff[tlpw_pkg::TBL_IDX_LSB +: tlpw_pkg::INDEX_W];
            rsp_in.table_valid = rdata_ff[tlpw_pkg::ENTRY_VALID];
            rsp_in.table_frame = rdata_ff[tlpw_pkg::FRAME_W-1:0];
         end
         tlpw_pkg::STATUS_OK: begin
            rsp_in.dir_index   = va_ff[tlpw_pkg::DIR_IDX_LSB +: tlpw_pkg::INDEX_W];
            rsp_in.dir_valid   = dir_entry_ff[tlpw_pkg::ENTRY_VALID];
            rsp_in.dir_frame   = dir_entry_ff[tlpw_pkg::FRAME_W-1:0];
            rsp_in.table_index = va_ff[tlpw_pkg::TBL_IDX_LSB +: tlpw_pkg::INDEX_W];
            rsp_in.table_valid = tbl_entry_ff[tlpw_pkg::ENTRY_VALID];
            rsp_in.table_frame = tbl_entry_ff[tlpw_pkg::FRAME_W-1:0];
            rsp_in.phys_addr   = {tbl_entry_ff[tlpw_pkg::FRAME_W-1:0],
                                  va_ff[tlpw_pkg::OFFSET_W-1:0]};
            rsp_in.read_value  = rdata_ff;
         end
         default: begin
            rsp_in.status = tlpw_pkg::STATUS_WRITE_DONE;
         end
      endcase
   end

   assign stat.entry_valid = rdata_ff[tlpw_pkg::ENTRY_VALID];
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_data         = rsp_ff;

endmodule

@@ rtl/two_level_page_walk_top.sv @@
// ---------------------------------------------------------------------------
// two_level_page_walk_top: small MMU with a two-level page table walk
// Byte-wide physical memory of 4096 bytes, loaded by write commands and
// read by translate commands through a directory and a page table.
// ---------------------------------------------------------------------------
// Usage:
// A command transfer happens at a rising edge with start high and busy low.
// A write command stores req_data.write_data at req_data.write_addr and its
// result (status write done) appears in the next cycle; busy stays low, so a
// new command may follow in the very next cycle.
// A translate command reads the directory entry in the accept cycle, then
// the table entry, then the data byte, each a single read of the one
// synchronous memory port. Its result is loaded in the data state, or in
// the directory or table check on a fault. busy stays high until the
// walker is back in idle, so a new command waits for the walk to finish,
// the chain of three dependent memory reads setting the pace.
// Each result is shown on rsp_data for exactly one cycle with rsp_strobe
// high; the receiver cannot stall it, and the next command may be taken in
// that same cycle because the result sits in its own output register.
// The directory base is written on the csr channel while busy is low.
// Reset sets the directory base to 0x220 and returns the walker to idle;
// the memory contents are undefined until written.
// ---------------------------------------------------------------------------
module two_level_page_walk_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tlpw_pkg::req_type           req_data,
   output logic                        rsp_strobe,
   output tlpw_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tlpw_pkg::ADDR_W-1:0] csr_data
);

   tlpw_pkg::ctl_cmd_type ctl;
   tlpw_pkg::dp_stat_type stat;
   logic                  busy_int;
   logic                  csr_we;

   // The register only changes between commands, so the csr channel is
   // ready whenever no walk is in progress.
   assign csr_ready = ~busy_int;
   assign csr_we    = csr_valid & ~busy_int;
   assign busy      = busy_int;

   tlpw_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .stat    (stat),
      .ctl     (ctl),
      .busy    (busy_int)
   );

   tlpw_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_data   (csr_data),
      .ctl        (ctl),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
